// ===== src/lft_pkg.sv =====
// Shared types, sizes and register indexes for the LANC frame transceiver.
// Used by lft_cfg_regs, lft_engine and lanc_frame_transceiver_unit.
package lft_pkg;

  // Frame and counter sizing.
  localparam int FRAME_BYTES = 8;
  localparam int COUNT_BITS  = 12;
  localparam int BYTE_W      = 3;
  localparam int CFG_DATA_W  = 12;
  localparam int CFG_IDX_W   = 3;

  typedef logic [COUNT_BITS-1:0] count_t;

  localparam count_t CMAX = {COUNT_BITS{1'b1}};

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_TX_TYPE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TX_CODE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_TICKS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_GAP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BYTE_GAP   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GLITCH     = 3'd5;

  // Register reset values.
  localparam logic [9:0]  RST_BIT_TICKS = 10'd104;
  localparam logic [11:0] RST_FRAME_GAP = 12'd2500;
  localparam logic [11:0] RST_BYTE_GAP  = 12'd416;
  localparam logic [4:0]  RST_GLITCH    = 5'd7;

  // Reciprocal of five scaled by 2^16, rounded up; exact for dividends below 4096.
  localparam logic [13:0] RECIP5 = 14'd13108;

  // Configuration as seen by the engine, with tick targets already clamped.
  typedef struct packed {
    logic [7:0] tx_type;
    logic [7:0] tx_code;
    count_t     bit_tgt;     // one bit period
    count_t     bit15_tgt;   // one and a half bit periods
    count_t     tail_tgt;    // 0.6 bit period
    count_t     frame_gap_tgt;
    count_t     byte_gap_tgt;
    count_t     glitch_tgt;
  } cfg_t;

  // One result word.
  typedef struct packed {
    logic              drive_low;
    logic              byte_valid;
    logic [BYTE_W-1:0] byte_index;
    logic [7:0]        byte_value;
    logic              frame_end;
    logic              start_timeout;
    logic              busy_res;
  } res_t;

  // Clamp a tick target to the counter's range.
  function automatic count_t clampc(input logic [15:0] v);
    count_t r;
    if (v > 16'(CMAX)) begin
      r = CMAX;
    end else begin
      r = v[COUNT_BITS-1:0];
    end
    return r;
  endfunction

  // Saturating increment of a tick counter.
  function automatic count_t incc(input count_t v);
    count_t r;
    if (v == CMAX) begin
      r = CMAX;
    end else begin
      r = v + 1'b1;
    end
    return r;
  endfunction

endpackage

// ===== src/lft_cfg_regs.sv =====
// Configuration registers of the LANC frame transceiver and the tick targets
// derived from them. Depends on lft_pkg.
module lft_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [lft_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lft_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output lft_pkg::cfg_t                 cfg_o
);

  logic [7:0]  tx_type_r;
  logic [7:0]  tx_code_r;
  logic [9:0]  bit_ticks_r;
  logic [11:0] frame_gap_r;
  logic [11:0] byte_gap_r;
  logic [4:0]  glitch_r;

  logic [11:0] bit3;
  logic [25:0] tail_prod;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_type_r   <= '0;
      tx_code_r   <= '0;
      bit_ticks_r <= lft_pkg::RST_BIT_TICKS;
      frame_gap_r <= lft_pkg::RST_FRAME_GAP;
      byte_gap_r  <= lft_pkg::RST_BYTE_GAP;
      glitch_r    <= lft_pkg::RST_GLITCH;
    end else if (cfg_we) begin
      case (cfg_index)
        lft_pkg::REG_TX_TYPE:   tx_type_r   <= cfg_wdata[7:0];
        lft_pkg::REG_TX_CODE:   tx_code_r   <= cfg_wdata[7:0];
        lft_pkg::REG_BIT_TICKS: bit_ticks_r <= cfg_wdata[9:0];
        lft_pkg::REG_FRAME_GAP: frame_gap_r <= cfg_wdata[11:0];
        lft_pkg::REG_BYTE_GAP:  byte_gap_r  <= cfg_wdata[11:0];
        lft_pkg::REG_GLITCH:    glitch_r    <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  // 0.6 bit period is floor(3 * bit_ticks / 5), done as a reciprocal multiply.
  assign bit3      = (12'(bit_ticks_r) << 1) + 12'(bit_ticks_r);
  assign tail_prod = 26'(bit3) * 26'(lft_pkg::RECIP5);

  always_comb begin
    cfg_o.tx_type       = tx_type_r;
    cfg_o.tx_code       = tx_code_r;
    cfg_o.bit_tgt       = lft_pkg::clampc(16'(bit_ticks_r));
    cfg_o.bit15_tgt     = lft_pkg::clampc(16'(bit_ticks_r) + 16'(bit_ticks_r >> 1));
    cfg_o.tail_tgt      = lft_pkg::clampc(16'(tail_prod[25:16]));
    cfg_o.frame_gap_tgt = lft_pkg::clampc(16'(frame_gap_r));
    cfg_o.byte_gap_tgt  = lft_pkg::clampc(16'(byte_gap_r));
    cfg_o.glitch_tgt    = lft_pkg::clampc(16'(glitch_r));
  end

endmodule

// ===== src/lft_engine.sv =====
// Frame state machine of the LANC frame transceiver: one step per tick word.
// Depends on lft_pkg.
module lft_engine (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step_i,
  input  logic          line_i,
  input  logic          req_i,
  input  lft_pkg::cfg_t cfg_i,
  output lft_pkg::res_t res_o
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_GAP,
    PH_WAIT,
    PH_CONFIRM,
    PH_START,
    PH_DATA,
    PH_TAIL
  } phase_t;

  phase_t                       phase_r, phase_nxt;
  lft_pkg::count_t              tick_r, tick_nxt;
  lft_pkg::count_t              run_r, run_nxt;
  logic [lft_pkg::BYTE_W-1:0]   bp_r, bp_nxt;
  logic [2:0]                   bit_r, bit_nxt;
  logic [7:0]                   sh_r, sh_nxt;
  logic                         to_r, to_nxt;

  lft_pkg::count_t              tick_inc;
  logic [lft_pkg::BYTE_W:0]     bp_inc;
  logic                         is_write;
  logic                         last_byte;
  logic [7:0]                   tx_byte;
  logic [7:0]                   sh_or;
  logic                         emit;
  logic [7:0]                   val;

  assign tick_inc  = lft_pkg::incc(tick_r);
  assign bp_inc    = {1'b0, bp_r} + 1'b1;
  assign is_write  = (bp_r < 3'd2);
  assign last_byte = (bp_inc >= (lft_pkg::BYTE_W + 1)'(lft_pkg::FRAME_BYTES));
  assign tx_byte   = (bp_r == 3'd0) ? cfg_i.tx_type :
                     (bp_r == 3'd1) ? cfg_i.tx_code : 8'd0;
  assign sh_or     = sh_r | (8'(line_i) << bit_r);

  always_comb begin
    phase_nxt = phase_r;
    tick_nxt  = tick_r;
    run_nxt   = run_r;
    bp_nxt    = bp_r;
    bit_nxt   = bit_r;
    sh_nxt    = sh_r;
    to_nxt    = to_r;
    emit      = 1'b0;
    val       = 8'd0;

    case (phase_r)
      PH_IDLE: begin
        if (req_i) begin
          phase_nxt = PH_GAP;
          run_nxt   = '0;
        end
      end
      PH_GAP: begin
        run_nxt = line_i ? lft_pkg::incc(run_r) : '0;
        if (run_nxt >= cfg_i.frame_gap_tgt) begin
          phase_nxt = PH_WAIT;
          bp_nxt    = '0;
          tick_nxt  = '0;
          to_nxt    = 1'b0;
        end
      end
      PH_WAIT: begin
        if (!line_i) begin
          phase_nxt = PH_CONFIRM;
          tick_nxt  = '0;
        end else if (bp_r != 3'd0) begin
          // The first byte of a frame waits for its edge without a timeout.
          tick_nxt = tick_inc;
          if (tick_inc >= cfg_i.byte_gap_tgt) begin
            to_nxt    = 1'b1;
            phase_nxt = PH_START;
            tick_nxt  = '0;
            sh_nxt    = tx_byte;
          end
        end
      end
      PH_CONFIRM: begin
        tick_nxt = tick_inc;
        if (tick_inc >= cfg_i.glitch_tgt) begin
          if (!line_i) begin
            phase_nxt = PH_START;
            sh_nxt    = tx_byte;
          end else begin
            phase_nxt = PH_WAIT;
            tick_nxt  = '0;
          end
        end
      end
      PH_START: begin
        tick_nxt = tick_inc;
        if (is_write) begin
          if (tick_inc >= cfg_i.bit_tgt) begin
            phase_nxt = PH_DATA;
            bit_nxt   = 3'd0;
            tick_nxt  = '0;
          end
        end else if (tick_inc >= cfg_i.bit15_tgt) begin
          sh_nxt    = 8'(line_i);
          phase_nxt = PH_DATA;
          bit_nxt   = 3'd1;
          tick_nxt  = '0;
        end
      end
      PH_DATA: begin
        tick_nxt = tick_inc;
        if (tick_inc >= cfg_i.bit_tgt) begin
          tick_nxt = '0;
          if (is_write) begin
            if (bit_r == 3'd7) begin
              emit = 1'b1;
              val  = sh_r;
            end else begin
              bit_nxt = bit_r + 1'b1;
            end
          end else begin
            sh_nxt = sh_or;
            if (bit_r == 3'd7) begin
              emit   = 1'b1;
              val    = ~sh_or;
              sh_nxt = ~sh_or;
            end else begin
              bit_nxt = bit_r + 1'b1;
            end
          end
        end
      end
      PH_TAIL: begin
        tick_nxt = tick_inc;
        if (tick_inc >= cfg_i.tail_tgt) begin
          phase_nxt = last_byte ? PH_IDLE : PH_WAIT;
          bp_nxt    = last_byte ? '0 : bp_inc[lft_pkg::BYTE_W-1:0];
          tick_nxt  = '0;
          to_nxt    = 1'b0;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase

    // A written byte moves straight on; a read byte waits out its tail first.
    if (emit) begin
      tick_nxt = '0;
      if (is_write) begin
        phase_nxt = last_byte ? PH_IDLE : PH_WAIT;
        bp_nxt    = last_byte ? '0 : bp_inc[lft_pkg::BYTE_W-1:0];
        to_nxt    = 1'b0;
      end else begin
        phase_nxt = PH_TAIL;
      end
    end
  end

  always_comb begin
    res_o.drive_low     = (phase_nxt == PH_DATA) && (bp_nxt < 3'd2) && sh_nxt[bit_nxt];
    res_o.byte_valid    = emit;
    res_o.byte_index    = emit ? bp_r : '0;
    res_o.byte_value    = val;
    res_o.frame_end     = emit && last_byte;
    res_o.start_timeout = emit && to_r;
    res_o.busy_res      = (phase_nxt != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      tick_r  <= '0;
      run_r   <= '0;
      bp_r    <= '0;
      bit_r   <= '0;
      sh_r    <= '0;
      to_r    <= 1'b0;
    end else if (step_i) begin
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      run_r   <= run_nxt;
      bp_r    <= bp_nxt;
      bit_r   <= bit_nxt;
      sh_r    <= sh_nxt;
      to_r    <= to_nxt;
    end
  end

  // The line is never pulled low on the tick a byte completes.
  a_no_drive_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
    step_i && res_o.byte_valid |-> !res_o.drive_low)
    else $error("drive_low set with a completed byte");

  // The last byte of a frame is a read byte, so its tail always follows.
  a_frame_end_tail: assert property (@(posedge clk) disable iff (!rst_n)
    step_i && res_o.frame_end |=> phase_r == PH_TAIL)
    else $error("frame ended without entering the tail");

  // A timeout flag is only ever held while bytes after the first are handled.
  a_timeout_byte: assert property (@(posedge clk) disable iff (!rst_n)
    to_r |-> bp_r != 3'd0)
    else $error("timeout flag on the first byte");

endmodule

// ===== src/lanc_frame_transceiver_unit.sv =====
// Top level of the LANC frame transceiver: tick input register, frame engine,
// result register and configuration registers. Depends on lft_pkg, lft_cfg_regs, lft_engine.
//
//   Channel   Direction  Handshake              Payload
//   in_       input      in_valid / in_ready    in_line_in, in_frame_request
//   out_      output     out_valid / out_ready  drive_low .. busy_res
//   cfg_      input      cfg_we (no wait)       cfg_index, cfg_wdata
//
// One tick word is accepted every clock cycle when the result side keeps up.
// A word waits in the input register until the result register can take a new word; the
// engine then steps once and its result is loaded into the output register, so out_valid
// rises once the result is registered, and the result is held until out_ready takes it.
// Reset is synchronous and active low; it clears the frame state, the valid flags
// and sets the registers to their defaults. A stall on out_ready holds the result
// register, then the input register, and only then drops in_ready.
module lanc_frame_transceiver_unit (
  input  logic                           clk,
  input  logic                           rst_n,

  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_line_in,
  input  logic                           in_frame_request,

  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_drive_low,
  output logic                           out_byte_valid,
  output logic [lft_pkg::BYTE_W-1:0]     out_byte_index,
  output logic [7:0]                     out_byte_value,
  output logic                           out_frame_end,
  output logic                           out_start_timeout,
  output logic                           out_busy_res,

  input  logic                           cfg_we,
  input  logic [lft_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lft_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  lft_pkg::cfg_t cfg;
  lft_pkg::res_t res;
  lft_pkg::res_t out_res_r;

  logic in_vld_r;
  logic in_line_r;
  logic in_req_r;
  logic out_vld_r;
  logic adv;
  logic step;

  // The result register can take a new word when it is empty or being drained.
  assign adv      = !out_vld_r || out_ready;
  assign step     = in_vld_r && adv;
  assign in_ready = !in_vld_r || adv;

  lft_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  lft_engine u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_i (step),
    .line_i (in_line_r),
    .req_i  (in_req_r),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Input register: control state only is reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_line_r <= in_line_in;
      in_req_r  <= in_frame_request;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res_r <= res;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_drive_low     = out_res_r.drive_low;
  assign out_byte_valid    = out_res_r.byte_valid;
  assign out_byte_index    = out_res_r.byte_index;
  assign out_byte_value    = out_res_r.byte_value;
  assign out_frame_end     = out_res_r.frame_end;
  assign out_start_timeout = out_res_r.start_timeout;
  assign out_busy_res      = out_res_r.busy_res;

  // An empty result register never blocks the input side.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_vld_r |-> in_ready)
    else $error("input stalled with an empty result register");

  // A word that steps the engine shows up as a result in the next cycle.
  a_step_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_vld_r)
    else $error("engine step without a result");

  // A result that is not taken stays in place.
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_ready |=> out_vld_r && $stable(out_res_r))
    else $error("pending result lost or changed");

endmodule
